// ===== src/dpts_pkg.sv =====
// Shared types, widths and constants for the top-k inner product search block.
// No dependencies; every other file but dpts_chan_if imports this package.
`timescale 1ns / 1ps

package dpts_pkg;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 32;
  localparam int SCORE_W = 40;
  localparam int ROW_W   = 16;
  localparam int DIM_W   = 9;
  localparam int KEEP_W  = 6;

  localparam int MAX_DIM_DEF  = 256;
  localparam int MAX_KEEP_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 2'd1;
  localparam logic [DIM_W-1:0]     DIM_RESET      = 9'd64;
  localparam logic [KEEP_W-1:0]    KEEP_RESET     = 6'd8;

  typedef struct packed {
    logic                      req_type;
    logic signed [ELEM_W-1:0]  elem_value;
    logic                      final_elem;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row_number;
    logic signed [SCORE_W-1:0] row_score;
    logic                      last_result;
  } out_item_t;

  // one entry of the ranked list
  typedef struct packed {
    logic [ROW_W-1:0]          row;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // side info that travels with a database element through the MAC pipe
  typedef struct packed {
    logic             close;
    logic             fin;
    logic [ROW_W-1:0] row;
  } elem_tag_t;

  // finished row handed to the ranking unit
  typedef struct packed {
    logic                      valid;
    logic                      fin;
    logic [ROW_W-1:0]          row;
    logic signed [SCORE_W-1:0] score;
  } ins_req_t;

  typedef enum logic [2:0] {
    TK_IDLE,
    TK_FULL,
    TK_SHIFT,
    TK_PUT,
    TK_RPT_RD,
    TK_RPT_LD
  } topk_state_t;

endpackage

// ===== src/dpts_chan_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// No dependencies.
`timescale 1ns / 1ps

interface dpts_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/dpts_dot.sv =====
// Query memory and multiply-accumulate pipeline; emits one score per closed row.
// Depends on dpts_pkg.
`timescale 1ns / 1ps

module dpts_dot #(
  parameter int MAX_DIM = dpts_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_we,
  input  logic                                db_en,
  input  logic [$clog2(MAX_DIM)-1:0]          q_addr,
  input  logic signed [dpts_pkg::ELEM_W-1:0]  elem,
  input  dpts_pkg::elem_tag_t                 tag,
  output dpts_pkg::ins_req_t                  ins
);
  import dpts_pkg::*;

  logic signed [ELEM_W-1:0]  qmem [MAX_DIM];
  logic signed [ELEM_W-1:0]  q_rd_r;

  logic                      s1_v_r;
  logic signed [ELEM_W-1:0]  s1_val_r;
  elem_tag_t                 s1_tag_r;

  logic                      s2_v_r;
  logic signed [PROD_W-1:0]  s2_prod_r;
  elem_tag_t                 s2_tag_r;

  logic signed [SCORE_W-1:0] acc_r;
  logic signed [SCORE_W-1:0] sum;
  logic                      ins_v_r;
  logic                      ins_fin_r;
  logic [ROW_W-1:0]          ins_row_r;
  logic signed [SCORE_W-1:0] ins_score_r;

  // query store: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_addr] <= elem;
    end
    if (db_en) begin
      q_rd_r <= qmem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    s1_val_r  <= elem;
    s1_tag_r  <= tag;
    s2_prod_r <= q_rd_r * s1_val_r;
    s2_tag_r  <= s1_tag_r;
  end

  assign sum = acc_r + {{(SCORE_W-PROD_W){s2_prod_r[PROD_W-1]}}, s2_prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      acc_r   <= '0;
      ins_v_r <= 1'b0;
    end else begin
      s1_v_r  <= db_en;
      s2_v_r  <= s1_v_r;
      ins_v_r <= s2_v_r && s2_tag_r.close;
      if (s2_v_r) begin
        acc_r <= s2_tag_r.close ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_fin_r   <= s2_tag_r.fin;
    ins_row_r   <= s2_tag_r.row;
    ins_score_r <= sum;
  end

  assign ins = '{valid: ins_v_r, fin: ins_fin_r, row: ins_row_r, score: ins_score_r};

endmodule

// ===== src/dpts_topk.sv =====
// Ranked list memory with tail-first sorted insertion and the result reader.
// Depends on dpts_pkg and dpts_chan_if.
`timescale 1ns / 1ps

module dpts_topk #(
  parameter int MAX_KEEP = dpts_pkg::MAX_KEEP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_KEEP+1)-1:0]  keep,
  input  dpts_pkg::ins_req_t             ins,
  dpts_chan_if.source                    out_ch,
  output logic                           done
);
  import dpts_pkg::*;

  localparam int KW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KCW = $clog2(MAX_KEEP+1);

  entry_t          lmem [MAX_KEEP];
  entry_t          rd_r;
  logic            mem_we, mem_re;
  logic [KW-1:0]   mem_wa, mem_ra;
  entry_t          mem_wd;

  topk_state_t     state_r, state_nxt;
  logic [KCW-1:0]  fill_r, fill_nxt;
  logic [KCW-1:0]  n_r, n_nxt;
  logic [KW-1:0]   j_r, j_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  entry_t          new_r, new_nxt;
  logic            fin_r, fin_nxt;
  out_item_t       out_r;
  logic            out_valid_r;
  logic            out_load;

  logic [KCW-1:0]  n_cur;
  logic            full_now;
  logic            ge;
  logic [KW-1:0]   keep_last;
  logic            last_res;
  logic            slot_free;

  assign n_cur     = (fill_r < keep) ? fill_r : keep;
  assign full_now  = (n_cur == keep);
  assign ge        = $signed(rd_r.score) >= $signed(new_r.score);
  assign keep_last = KW'(keep - KCW'(1));
  assign last_res  = ((KCW'(k_r) + KCW'(1)) == n_r);
  assign slot_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lmem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_r <= lmem[mem_ra];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      TK_IDLE: begin
        if (ins.valid) begin
          if (full_now)          state_nxt = TK_FULL;
          else if (n_cur == '0)  state_nxt = ins.fin ? TK_RPT_RD : TK_IDLE;
          else                   state_nxt = TK_SHIFT;
        end
      end
      TK_FULL: begin
        if (ge || keep_last == '0) state_nxt = fin_r ? TK_RPT_RD : TK_IDLE;
        else                       state_nxt = TK_SHIFT;
      end
      TK_SHIFT: begin
        if (!ge) state_nxt = (j_r == KW'(1)) ? TK_PUT : TK_SHIFT;
        else     state_nxt = fin_r ? TK_RPT_RD : TK_IDLE;
      end
      TK_PUT:    state_nxt = fin_r ? TK_RPT_RD : TK_IDLE;
      TK_RPT_RD: state_nxt = slot_free ? TK_RPT_LD : TK_RPT_RD;
      TK_RPT_LD: state_nxt = last_res ? TK_IDLE : TK_RPT_RD;
      default:   state_nxt = TK_IDLE;
    endcase
  end

  // memory control and datapath
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = new_r;
    mem_re   = 1'b0;
    mem_ra   = '0;
    fill_nxt = fill_r;
    n_nxt    = n_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    new_nxt  = new_r;
    fin_nxt  = fin_r;
    done     = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      TK_IDLE: begin
        if (ins.valid) begin
          new_nxt = '{row: ins.row, score: ins.score};
          fin_nxt = ins.fin;
          k_nxt   = '0;
          if (full_now) begin
            mem_re = 1'b1;
            mem_ra = keep_last;
            n_nxt  = keep;
          end else if (n_cur == '0) begin
            // empty list: new row lands in slot 0 at once
            mem_we   = 1'b1;
            mem_wd   = '{row: ins.row, score: ins.score};
            n_nxt    = KCW'(1);
            fill_nxt = KCW'(1);
            done     = !ins.fin;
          end else begin
            mem_re = 1'b1;
            mem_ra = KW'(n_cur - KCW'(1));
            j_nxt  = KW'(n_cur);
            n_nxt  = n_cur + KCW'(1);
          end
        end
      end
      TK_FULL: begin
        if (ge) begin
          // list full and new score no better than the tail: dropped
          fill_nxt = n_r;
          done     = !fin_r;
        end else if (keep_last == '0) begin
          mem_we   = 1'b1;
          fill_nxt = n_r;
          done     = !fin_r;
        end else begin
          mem_re = 1'b1;
          mem_ra = keep_last - KW'(1);
          j_nxt  = keep_last;
        end
      end
      TK_SHIFT: begin
        mem_we = 1'b1;
        mem_wa = j_r;
        if (!ge) begin
          mem_wd = rd_r;
          j_nxt  = j_r - KW'(1);
          if (j_r != KW'(1)) begin
            mem_re = 1'b1;
            mem_ra = j_r - KW'(2);
          end
        end else begin
          fill_nxt = n_r;
          done     = !fin_r;
        end
      end
      TK_PUT: begin
        mem_we   = 1'b1;
        fill_nxt = n_r;
        done     = !fin_r;
      end
      TK_RPT_RD: begin
        if (slot_free) begin
          mem_re = 1'b1;
          mem_ra = k_r;
        end
      end
      TK_RPT_LD: begin
        out_load = 1'b1;
        if (last_res) begin
          fill_nxt = '0;
          done     = 1'b1;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TK_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    new_r   <= new_nxt;
    fin_r   <= fin_nxt;
    if (out_load) begin
      out_r <= '{row_number: rd_r.row, row_score: rd_r.score, last_result: last_res};
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

endmodule

// ===== src/dot_product_topk_search_core.sv =====
// Top level of the top-k maximum inner product search block.
// Depends on dpts_pkg, dpts_chan_if, dpts_dot and dpts_topk.
`timescale 1ns / 1ps
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  in_ch    | in  | req_type, elem_value, final_elem          | valid/ready
//  out_ch   | out | row_number, row_score, last_result        | valid/ready
//  cfg_*    | in  | cfg_index, cfg_wdata (dim_in_use, keep)   | cfg_we only
//
// Query elements and non-closing database elements are taken one per cycle
// while no closed row is pending. An element that closes a row holds in_ch
// through the MAC pipe (memory read, multiply, accumulate with hand-off) and
// through sorted insertion: the list memory moves one entry per cycle from the tail.
// On the final element each result then goes through a list memory read and a
// load of the output register, and waits while out_ch stalls.
// The output register is separate from the input side; a result waiting
// there does not block the next item once the report is over.
// Reset (rst_n low at a clock edge) clears counters and list fill and restores the
// config defaults; query memory and list memory contents are not cleared.

module dot_product_topk_search_core #(
  parameter int MAX_DIM  = dpts_pkg::MAX_DIM_DEF,
  parameter int MAX_KEEP = dpts_pkg::MAX_KEEP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dpts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpts_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  dpts_chan_if.sink                          in_ch,
  dpts_chan_if.source                        out_ch
);
  import dpts_pkg::*;

  localparam int AW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM+1);
  localparam int DCMP = (DW > DIM_W) ? DW : DIM_W;
  localparam int KCW  = $clog2(MAX_KEEP+1);
  localparam int KCMP = (KCW > KEEP_W) ? KCW : KEEP_W;

  // configuration
  logic [DIM_W-1:0]  dim_r;
  logic [KEEP_W-1:0] keep_r;
  logic [DCMP-1:0]   dim_ext;
  logic [KCMP-1:0]   keep_ext;
  logic [DW-1:0]     dim_eff;
  logic [KCW-1:0]    keep_eff;

  // sequencing state
  logic [AW-1:0]     fill_r;    // next query slot
  logic [AW-1:0]     epos_r;    // position inside the current row
  logic [ROW_W-1:0]  rowc_r;
  logic              busy_r;    // row closed, ranking or report in progress

  logic              accept, is_db, fin, close;
  logic [AW-1:0]     qpos;
  logic [DW-1:0]     qpos_inc, epos_inc;
  elem_tag_t         tag;
  ins_req_t          ins;
  logic              done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= DIM_RESET;
      keep_r <= KEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIM_IN_USE: dim_r  <= cfg_wdata[DIM_W-1:0];
        CFG_KEEP_COUNT: keep_r <= cfg_wdata[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp registers to 1..MAX
  assign dim_ext  = DCMP'(dim_r);
  assign keep_ext = KCMP'(keep_r);
  always_comb begin
    if (dim_r == '0)                     dim_eff = DW'(1);
    else if (dim_ext > DCMP'(MAX_DIM))   dim_eff = DW'(MAX_DIM);
    else                                 dim_eff = DW'(dim_ext);
    if (keep_r == '0)                    keep_eff = KCW'(1);
    else if (keep_ext > KCMP'(MAX_KEEP)) keep_eff = KCW'(MAX_KEEP);
    else                                 keep_eff = KCW'(keep_ext);
  end

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign is_db       = in_ch.payload.req_type;
  assign fin         = in_ch.payload.final_elem;

  // query load slot; a stale fill past the length restarts at zero
  assign qpos     = (DW'(fill_r) < dim_eff) ? fill_r : '0;
  assign qpos_inc = DW'(qpos) + DW'(1);

  // a row closes at its last position, or early on the final element
  assign epos_inc = DW'(epos_r) + DW'(1);
  assign close    = fin || (epos_inc >= dim_eff);

  assign tag = '{close: close, fin: fin, row: rowc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      epos_r <= '0;
      rowc_r <= '0;
      busy_r <= 1'b0;
    end else begin
      if (accept && !is_db) begin
        fill_r <= (qpos_inc >= dim_eff) ? '0 : AW'(qpos_inc);
      end
      if (accept && is_db) begin
        if (close) begin
          epos_r <= '0;
          rowc_r <= fin ? '0 : rowc_r + ROW_W'(1);
          busy_r <= 1'b1;
        end else begin
          epos_r <= AW'(epos_inc);
        end
      end else if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  dpts_dot #(
    .MAX_DIM (MAX_DIM)
  ) u_dot (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_we   (accept && !is_db),
    .db_en  (accept && is_db),
    .q_addr (is_db ? epos_r : qpos),
    .elem   (in_ch.payload.elem_value),
    .tag    (tag),
    .ins    (ins)
  );

  dpts_topk #(
    .MAX_KEEP (MAX_KEEP)
  ) u_topk (
    .clk    (clk),
    .rst_n  (rst_n),
    .keep   (keep_eff),
    .ins    (ins),
    .out_ch (out_ch),
    .done   (done)
  );

  // a finished row only reaches the ranking unit while the input is held
  a_ins_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ins.valid |-> busy_r)
    else $error("row score handed off while input open");

  a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r)
    else $error("ranking done without a pending row");

  // a result is loaded only while the input is held; the last one on the same edge that reopens it
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(busy_r))
    else $error("result produced outside a report");

endmodule

// ===== dv/tb.sv =====
// Self-checking bench for the top-k inner product search core: streams query and
// database elements, predicts the ranked report and checks every result item.
// Depends on dpts_pkg, dpts_chan_if and the core RTL.
`timescale 1ns / 1ps

module tb;
  import dpts_pkg::*;

  localparam int QUIET_LIMIT   = 5000;  // cycles with no item moving on either channel
  localparam int SETTLE_CYCLES = 64;    // covers MAC pipe plus a full-length insertion
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int PHASE_ITEMS   = 35;    // random items per idling mode

  // Ranked-list predictor plus the queue of result items still owed by the core.
  class topk_ledger;
    logic [DIM_W-1:0]          dim_reg;
    logic [KEEP_W-1:0]         keep_reg;
    logic signed [ELEM_W-1:0]  query_vec [MAX_DIM_DEF];
    bit                        query_set [MAX_DIM_DEF];
    int unsigned               query_fill;
    int unsigned               elem_pos;
    int unsigned               best_n;
    logic [ROW_W-1:0]          row_cnt;
    logic signed [SCORE_W-1:0] dot_acc;
    logic signed [SCORE_W-1:0] best_score [MAX_KEEP_DEF];
    logic [ROW_W-1:0]          best_row [MAX_KEEP_DEF];
    out_item_t                 due_ranks [$];
    int                        errors;

    function new();
      dim_reg    = DIM_RESET;
      keep_reg   = KEEP_RESET;
      query_fill = 0;
      elem_pos   = 0;
      best_n     = 0;
      row_cnt    = '0;
      dot_acc    = '0;
      errors     = 0;
      foreach (query_vec[i]) begin
        query_vec[i] = '0;
        query_set[i] = 1'b0;
      end
      foreach (best_score[i]) begin
        best_score[i] = '0;
        best_row[i]   = '0;
      end
    endfunction

    function int unsigned dim_eff();
      if (dim_reg == 0) return 1;
      if (dim_reg > MAX_DIM_DEF) return MAX_DIM_DEF;
      return dim_reg;
    endfunction

    function int unsigned keep_eff();
      if (keep_reg == 0) return 1;
      if (keep_reg > MAX_KEEP_DEF) return MAX_KEEP_DEF;
      return keep_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
      case (idx)
        CFG_DIM_IN_USE: dim_reg = wdata[DIM_W-1:0];
        CFG_KEEP_COUNT: keep_reg = wdata[KEEP_W-1:0];
        default: ;
      endcase
    endfunction

    // sorted insert; equal scores land behind the earlier row
    function void rank_row(logic signed [SCORE_W-1:0] score, logic [ROW_W-1:0] row);
      int unsigned keep, n, pos, i;
      keep = keep_eff();
      n    = (best_n < keep) ? best_n : keep;
      pos  = 0;
      while (pos < n && best_score[pos] >= score) pos++;
      if (pos >= keep) begin
        best_n = n;
        return;
      end
      if (n < keep) n++;
      for (i = n - 1; i > pos; i--) begin
        best_score[i] = best_score[i-1];
        best_row[i]   = best_row[i-1];
      end
      best_score[pos] = score;
      best_row[pos]   = row;
      best_n          = n;
    endfunction

    function void take_elem(in_item_t it);
      int unsigned d, p, n, k;
      logic signed [2*ELEM_W-1:0] prod;
      out_item_t r;
      d = dim_eff();
      if (!it.req_type) begin
        p = (query_fill < d) ? query_fill : 0;
        query_vec[p] = it.elem_value;
        query_set[p] = 1'b1;
        query_fill   = (p + 1 >= d) ? 0 : p + 1;
        return;
      end
      prod    = $signed(query_vec[elem_pos % MAX_DIM_DEF]) * $signed(it.elem_value);
      dot_acc = dot_acc + SCORE_W'(prod);
      if (elem_pos + 1 >= d || it.final_elem) begin
        rank_row(dot_acc, row_cnt);
        row_cnt++;
        dot_acc  = '0;
        elem_pos = 0;
      end else begin
        elem_pos++;
      end
      if (!it.final_elem) return;
      n = keep_eff();
      if (best_n < n) n = best_n;
      for (k = 0; k < n; k++) begin
        r.row_number  = best_row[k];
        r.row_score   = best_score[k];
        r.last_result = (k + 1 == n);
        due_ranks.push_back(r);
      end
      row_cnt  = '0;
      elem_pos = 0;
      dot_acc  = '0;
      best_n   = 0;
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (due_ranks.size() == 0) begin
        $error("unexpected result item: row_number %0d row_score %0d last_result %0d",
               got.row_number, got.row_score, got.last_result);
        errors++;
        return;
      end
      want = due_ranks.pop_front();
      if (got.row_number !== want.row_number) begin
        $error("row_number: expected %0d, got %0d", want.row_number, got.row_number);
        errors++;
      end
      if (got.row_score !== want.row_score) begin
        $error("row_score: expected %0d, got %0d", want.row_score, got.row_score);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dpts_chan_if #(.payload_t(in_item_t))  in_ch ();
  dpts_chan_if #(.payload_t(out_item_t)) out_ch ();

  dot_product_topk_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  topk_ledger ledger = new();

  int tx_idle_pct;   // chance in 100 that the sender skips a cycle
  int rx_idle_pct;   // chance in 100 that the receiver drops ready
  int hold_reqs;     // bumped by the stimulus to request a long hold-off
  int hold_seen;
  int hold_left;
  int quiet;
  int unsigned sent_items;

  always #6 clk = ~clk;

  // Receiver: random ready, or a long hold-off counted here once requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor: every accepted result item is checked against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) ledger.match_result(out_ch.payload);
  end

  // Watchdog on forward progress of either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic signed [ELEM_W-1:0] pick_val();
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom_range(4)) - 16'd2;   // small values make ties likely
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item, with random idle cycles ahead of it, and hold until accepted.
  task automatic send_item(input logic req, input logic signed [ELEM_W-1:0] v,
                           input logic fin);
    in_item_t it;
    it.req_type   = req;
    it.elem_value = v;
    it.final_elem = fin;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    ledger.take_elem(it);
    sent_items++;
  endtask

  // Database element; query loads go first if the needed query entry was never written.
  task automatic send_db(input logic signed [ELEM_W-1:0] v, input logic fin);
    while (!ledger.query_set[ledger.elem_pos % MAX_DIM_DEF])
      send_item(1'b0, pick_val(), 1'b0);
    send_item(1'b1, v, fin);
  endtask

  // Drain every owed result, then let the pipe and the insertion logic go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.due_ranks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    ledger.write_reg(idx, wdata);
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] d, k;
    settle();
    case ($urandom_range(7))
      0:       d = 0;                          // clamps to one element
      1:       d = 1;
      2:       d = CFG_DATA_W'(MAX_DIM_DEF);
      3:       d = CFG_DATA_W'($urandom_range(511, MAX_DIM_DEF + 1));
      default: d = CFG_DATA_W'($urandom_range(12, 2));
    endcase
    case ($urandom_range(7))
      0:       k = 0;
      1:       k = CFG_DATA_W'(MAX_KEEP_DEF);
      2:       k = 9'h1ff;                     // upper bits dropped, then clamped
      3:       k = CFG_DATA_W'($urandom_range(63, MAX_KEEP_DEF + 1));
      default: k = CFG_DATA_W'($urandom_range(31, 1));
    endcase
    write_reg(CFG_DIM_IN_USE, d);
    write_reg(CFG_KEEP_COUNT, k);
  endtask

  // One search: optional reconfig, optional fresh query, a few rows, final element.
  // Long dims use one short row cut off by the final element.
  task automatic random_search();
    int unsigned d, rows, len, r, e;
    if ($urandom_range(1)) random_config();
    d = ledger.dim_eff();
    if ($urandom_range(9) < 7)
      repeat ((d > 8) ? 8 : d) send_item(1'b0, pick_val(), ($urandom_range(19) == 0));
    rows = (d > 16) ? 1 : $urandom_range(12, 1);
    for (r = 0; r < rows; r++) begin
      len = (d > 16) ? $urandom_range(8, 1) : d;
      if (r == rows - 1 && $urandom_range(4) == 0) len = $urandom_range(len, 1);
      for (e = 0; e < len; e++) begin
        if ($urandom_range(29) == 0) send_item(1'b0, pick_val(), 1'b0);   // stray query load
        send_db(pick_val(), (r == rows - 1) && (e == len - 1));
      end
    end
  endtask

  task automatic random_phase(input int tx, input int rx);
    int unsigned start;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    start = sent_items;
    while (sent_items - start < PHASE_ITEMS) random_search();
  endtask

  initial begin
    int unsigned i;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_DIM_IN_USE;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    tx_idle_pct   = 17;
    rx_idle_pct   = 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // One-element rows: both registers out of range, extreme products, a tie,
    // and a final flag on a query load that must be ignored.
    write_reg(CFG_DIM_IN_USE, 0);
    write_reg(CFG_KEEP_COUNT, 40);
    send_item(1'b0, 16'sh8000, 1'b1);
    send_db(16'sh8000, 1'b0);
    send_db(16'sh7fff, 1'b0);
    send_db(16'sh0000, 1'b0);
    send_db(16'sh8000, 1'b0);       // same score as row 0, must rank behind it
    send_db(16'sh0001, 1'b1);
    settle();

    // Four-element rows with the list held to one entry; the final element
    // closes the second row after two elements.
    write_reg(CFG_DIM_IN_USE, 4);
    write_reg(CFG_KEEP_COUNT, 0);
    send_item(1'b0, 16'sh7fff, 1'b0);
    send_item(1'b0, 16'sh8000, 1'b0);
    send_item(1'b0, 16'sh0001, 1'b0);
    send_item(1'b0, 16'shffff, 1'b0);
    send_db(16'sh7fff, 1'b0);
    send_db(16'sh8000, 1'b0);
    send_db(16'sh8000, 1'b0);
    send_db(16'sh7fff, 1'b0);
    send_db(16'sh0001, 1'b0);
    send_db(16'sh0001, 1'b1);
    settle();

    // Three listed rows, then a row left open at position 3; dim drops to 2
    // (row closes late) and keep drops to 1 (tail of the list is dropped).
    write_reg(CFG_DIM_IN_USE, 1);
    write_reg(CFG_KEEP_COUNT, 3);
    send_db(16'sd100, 1'b0);
    send_db(-16'sd5, 1'b0);
    send_db(16'sd100, 1'b0);
    settle();
    write_reg(CFG_DIM_IN_USE, 4);
    send_db(16'sd7, 1'b0);
    send_db(-16'sd9, 1'b0);
    send_db(16'sd3, 1'b0);
    settle();
    write_reg(CFG_DIM_IN_USE, 2);
    write_reg(CFG_KEEP_COUNT, 1);
    send_db(16'sh7fff, 1'b1);
    settle();

    // --- back-pressure ---
    // A full 32-entry report meets a receiver that holds off for a long stretch
    // while the sender keeps offering the next search.
    write_reg(CFG_DIM_IN_USE, 1);
    write_reg(CFG_KEEP_COUNT, CFG_DATA_W'(MAX_KEEP_DEF));
    for (i = 0; i < 39; i++) send_db(pick_val(), 1'b0);
    hold_reqs <= hold_reqs + 1;
    send_db(pick_val(), 1'b1);
    random_search();
    settle();

    // --- random part, three idling modes ---
    random_phase(17, 79);
    random_phase(79, 17);
    random_phase(0, 0);

    settle();
    if (ledger.errors == 0 && ledger.due_ranks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dpts_pkg.sv
src/dpts_chan_if.sv
src/dpts_dot.sv
src/dpts_topk.sv
src/dot_product_topk_search_core.sv
dv/tb.sv
